// ===== rtl/core/tia_pkg.sv =====
`timescale 1ns / 1ps

package tia_pkg;

	// Field widths
	localparam int POS_W  = 14;
	localparam int ADDR_W = 14;
	localparam int CFG_W  = 3;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// Register indexes (paddr[2] selects the word)
	localparam logic REG_IDX_OCTETS = 1'b0;

	// Block geometry
	localparam int MAX_OCTETS     = 5;
	localparam int OCTET_BITS     = 1784;
	localparam int OCTET_SYMS     = 223;
	localparam int MAX_BLOCK_BITS = OCTET_BITS * MAX_OCTETS;
	localparam logic [CFG_W-1:0] OCTETS_RESET = CFG_W'(1);

	// Octet-count index: value n is held as n - 1
	localparam int IDX_W = 3;

	// Half position, column and product widths
	localparam int H_W     = POS_W - 1;
	localparam int COL_W   = $clog2(OCTET_SYMS * MAX_OCTETS);
	localparam int REM_W   = COL_W + 1;
	localparam int PRIME_W = 7;
	localparam int PROD_W  = $clog2(47 * OCTET_SYMS * MAX_OCTETS + 22);
	localparam int PAR_ADD = 21;

	// Reciprocal division by k2 = 223 * n
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_SCALE = 1 << RECIP_SHIFT;
	localparam int RECIP_W     = $clog2(RECIP_SCALE / OCTET_SYMS + 1);
	localparam int QUO_W       = 6;

	typedef logic [RECIP_W-1:0] recip_t;
	localparam recip_t RECIP_TAB [8] = '{
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 1)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 2)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 3)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 4)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 5)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 6)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 7)),
		RECIP_W'(RECIP_SCALE / (OCTET_SYMS * 8))
	};

	typedef logic [PRIME_W-1:0] prime_t;
	localparam prime_t PRIME_TAB [8] = '{
		PRIME_W'(31), PRIME_W'(37), PRIME_W'(43), PRIME_W'(47),
		PRIME_W'(53), PRIME_W'(59), PRIME_W'(61), PRIME_W'(67)
	};

	// Map the raw register to an index: zero acts as one, large values clamp
	function automatic logic [IDX_W-1:0] octet_idx(input logic [CFG_W-1:0] raw);
		logic [IDX_W-1:0] idx;
		if (raw == '0) begin
			idx = '0;
		end else if (int'(raw) > MAX_OCTETS) begin
			idx = IDX_W'(MAX_OCTETS - 1);
		end else begin
			idx = IDX_W'(raw - CFG_W'(1));
		end
		return idx;
	endfunction

	// Block length 1784 * n
	function automatic logic [POS_W-1:0] block_bits(input logic [IDX_W-1:0] idx);
		return POS_W'((int'(idx) + 1) * OCTET_BITS);
	endfunction

	// Row length k2 times a small row count
	function automatic logic [H_W-1:0] k2_times(input logic [IDX_W-1:0] idx, input int rows);
		return H_W'((int'(idx) + 1) * OCTET_SYMS * rows);
	endfunction

	// Row length k2 = 223 * n
	function automatic logic [COL_W-1:0] k2_of(input logic [IDX_W-1:0] idx);
		return COL_W'((int'(idx) + 1) * OCTET_SYMS);
	endfunction

	// (19 * row + 1) mod 4 reduces to row with its low bit flipped
	function automatic logic [1:0] row_to_t(input logic [1:0] row);
		return row ^ 2'b01;
	endfunction

endpackage

// ===== rtl/core/turbo_interleaver_address_core.sv =====
`timescale 1ns / 1ps
// Pipeline: a position request is loaded into the first of six register stages
// at the edge that accepts it, and the address is driven from the sixth.
// Throughput: one request per cycle while the output is not stalled; each of the six
// register stages advances on its own, so bubbles close up while the output is stalled.
// Reset: arst_n clears all stage valid bits and sets octets_q to 1.
// The reduction modulo 223*n uses a registered reciprocal multiply and a correction.
module turbo_interleaver_address_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tia_pkg::APB_AW-1:0] paddr,
	input  logic [tia_pkg::APB_DW-1:0] pwdata,
	output logic [tia_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tia_pkg::POS_W-1:0]  position,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tia_pkg::ADDR_W-1:0] address,
	output logic                       out_of_range
);
	import tia_pkg::*;

	logic [CFG_W-1:0] octets_q;
	logic [IDX_W-1:0] cfg_idx;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	// Stage 1: split the position, flag out-of-range
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [H_W-1:0]   h_s1;
	logic             m_s1;
	logic             oor_s1;

	// Stage 2: row and column
	logic             valid_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [1:0]       row_s2;
	logic [COL_W-1:0] col_s2;
	logic             m_s2;
	logic             oor_s2;

	// Stage 3: prime * column + 21 * parity
	logic              valid_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [1:0]        t_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              m_s3;
	logic              oor_s3;

	// Stage 4: quotient estimate
	logic              valid_s4;
	logic [IDX_W-1:0]  idx_s4;
	logic [1:0]        t_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [QUO_W-1:0]  quo_s4;
	logic              m_s4;
	logic              oor_s4;

	// Stage 5: partial remainder, below 2*k2
	logic             valid_s5;
	logic [IDX_W-1:0] idx_s5;
	logic [1:0]       t_s5;
	logic [REM_W-1:0] rem_s5;
	logic             m_s5;
	logic             oor_s5;

	// Stage 6: output register
	logic              valid_s6;
	logic [ADDR_W-1:0] addr_s6;
	logic              oor_s6;

	logic [H_W-1:0]              row_base;
	logic                        ge1, ge2, ge3;
	logic [1:0]                  row_next;
	logic [PROD_W+RECIP_W-1:0]   prod_recip;
	logic [PROD_W-1:0]           rem_full;
	logic [REM_W-1:0]            k2_ext;
	logic [COL_W-1:0]            col_fin;

	// Configuration register, written in the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octets_q <= OCTETS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_OCTETS) begin
			octets_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;

	// Read back the raw register value
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX_OCTETS) begin
			prdata = APB_DW'(octets_q);
		end
	end

	assign cfg_idx = octet_idx(octets_q);

	// Each stage loads when empty or when the next one moves
	assign rdy_s6   = !valid_s6 || !out_stall;
	assign rdy_s5   = !valid_s5 || rdy_s6;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
			if (rdy_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: capture the request
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			idx_s1 <= cfg_idx;
			h_s1   <= position[POS_W-1:1];
			m_s1   <= position[0];
			oor_s1 <= position >= block_bits(cfg_idx);
		end
	end

	// Find the row by comparing against multiples of k2
	always_comb begin
		ge1 = h_s1 >= k2_times(idx_s1, 1);
		ge2 = h_s1 >= k2_times(idx_s1, 2);
		ge3 = h_s1 >= k2_times(idx_s1, 3);
		if (ge3) begin
			row_next = 2'd3;
			row_base = k2_times(idx_s1, 3);
		end else if (ge2) begin
			row_next = 2'd2;
			row_base = k2_times(idx_s1, 2);
		end else if (ge1) begin
			row_next = 2'd1;
			row_base = k2_times(idx_s1, 1);
		end else begin
			row_next = 2'd0;
			row_base = '0;
		end
	end

	// Stage 2: row and column
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			idx_s2 <= idx_s1;
			row_s2 <= row_next;
			col_s2 <= COL_W'(h_s1 - row_base);
			m_s2   <= m_s1;
			oor_s2 <= oor_s1;
		end
	end

	// Stage 3: row-selected prime times column, plus the parity offset
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			idx_s3  <= idx_s2;
			t_s3    <= row_to_t(row_s2);
			prod_s3 <= PROD_W'(PRIME_TAB[{1'b0, row_to_t(row_s2)}]) * PROD_W'(col_s2)
				+ (m_s2 ? PROD_W'(PAR_ADD) : '0);
			m_s3    <= m_s2;
			oor_s3  <= oor_s2;
		end
	end

	// Quotient estimate, at most one below the true quotient
	assign prod_recip = (PROD_W+RECIP_W)'(prod_s3) * (PROD_W+RECIP_W)'(RECIP_TAB[idx_s3]);

	// Stage 4: quotient estimate
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			idx_s4  <= idx_s3;
			t_s4    <= t_s3;
			prod_s4 <= prod_s3;
			quo_s4  <= prod_recip[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
			m_s4    <= m_s3;
			oor_s4  <= oor_s3;
		end
	end

	assign rem_full = prod_s4 - PROD_W'(quo_s4) * PROD_W'(k2_of(idx_s4));

	// Stage 5: partial remainder
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			idx_s5 <= idx_s4;
			t_s5   <= t_s4;
			rem_s5 <= rem_full[REM_W-1:0];
			m_s5   <= m_s4;
			oor_s5 <= oor_s4;
		end
	end

	// Final correction of the remainder
	assign k2_ext  = REM_W'(k2_of(idx_s5));
	assign col_fin = (rem_s5 >= k2_ext) ? COL_W'(rem_s5 - k2_ext) : rem_s5[COL_W-1:0];

	// Stage 6: assemble 8*c + 2*t + 1 - m, zero when out of range
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			addr_s6 <= oor_s5 ? '0 : ADDR_W'({col_fin, t_s5, ~m_s5});
			oor_s6  <= oor_s5;
		end
	end

	assign out_valid    = valid_s6;
	assign address      = addr_s6;
	assign out_of_range = oor_s6;

endmodule

// ===== rtl/core/tia_checker.sv =====
`timescale 1ns / 1ps
module tia_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tia_pkg::ADDR_W-1:0] address,
	input logic                       out_of_range
);
	import tia_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(address) && $stable(out_of_range))
		else $error("stalled result changed");

	// Zero the address of an out-of-range request
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> address == '0)
		else $error("out-of-range result carries an address");

	// Keep in-range addresses inside the largest block
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |-> address < ADDR_W'(MAX_BLOCK_BITS))
		else $error("address beyond block");

	// Stall input only when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind turbo_interleaver_address_core tia_checker u_tia_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.address      (address),
	.out_of_range (out_of_range)
);
